// ===== src/conductor_fresnel_reflectance_defines.svh =====
// assertion helpers for the fresnel reflectance block
`ifndef CONDUCTOR_FRESNEL_REFLECTANCE_DEFINES_SVH
`define CONDUCTOR_FRESNEL_REFLECTANCE_DEFINES_SVH

// same-cycle implication
`define CFR_ASSERT_IMPLY(clk, rst, label, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CFR_ASSERT_NEXT(clk, rst, label, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/cfr_pkg.sv =====
package cfr_pkg;

   localparam int ONE_Q15 = 32768;
   localparam int ONE_Q16 = 65536;

   localparam int C_W    = 16;
   localparam int C2_W   = 17;
   localparam int SQ_W   = 32;
   localparam int T0_W   = 34;
   localparam int SQR_W  = 66;
   localparam int RAD_W  = 68;
   localparam int AB_W   = RAD_W / 2;
   localparam int ABR_W  = AB_W + 2;
   localparam int HALF_W = 34;
   localparam int ARG_W  = HALF_W + 16;
   localparam int A_W    = ARG_W / 2;
   localparam int AR_W   = A_W + 2;
   localparam int T1_W   = 35;
   localparam int T2_W   = 26;
   localparam int T3_W   = 35;
   localparam int T4_W   = 26;
   localparam int DEN_W  = 36;
   localparam int NUM_W  = 51;
   localparam int Q_W    = 16;
   localparam int RS_W   = Q_W + 1;
   localparam int SUM_W  = RS_W + 1;
   localparam int OUT_W  = 16;

   localparam int SQ1_N = RAD_W / 2;
   localparam int SQ2_N = ARG_W / 2;
   localparam int DIV_N = Q_W;

   typedef struct packed {
      logic [C_W-1:0]         c;
      logic [C2_W-1:0]        c2;
      logic [C2_W-1:0]        s2;
      logic signed [T0_W-1:0] t0;
   } side1_type;

   typedef struct packed {
      logic [ABR_W-1:0] rem;
      logic [AB_W-1:0]  root;
      logic [RAD_W-1:0] x;
      side1_type        side;
   } sq1_type;

   typedef struct packed {
      logic [C_W-1:0]  c;
      logic [C2_W-1:0] s2;
      logic [T1_W-1:0] t1;
      logic [T3_W-1:0] t3;
   } side2_type;

   typedef struct packed {
      logic [AR_W-1:0]  rem;
      logic [A_W-1:0]   root;
      logic [ARG_W-1:0] x;
      side2_type        side;
   } sq2_type;

   typedef struct packed {
      logic             neg1;
      logic             neg2;
      logic [T3_W-1:0]  mag2;
      logic [DEN_W-1:0] den2;
   } dside1_type;

   typedef struct packed {
      logic [NUM_W-1:0] rem;
      logic [DEN_W-1:0] den;
      logic [Q_W-1:0]   q;
      dside1_type       side;
   } dv1_type;

   typedef struct packed {
      logic signed [RS_W-1:0] rs;
      logic                   negp;
   } dside2_type;

   typedef struct packed {
      logic [NUM_W-1:0] rem;
      logic [DEN_W-1:0] den;
      logic [Q_W-1:0]   q;
      dside2_type       side;
   } dv2_type;

endpackage

// ===== src/conductor_fresnel_reflectance.sv =====
// throughput: one transfer per cycle while the buffer has room, set by the fully pipelined
//    roots (one bit per stage) and the two restoring dividers (one quotient bit per stage)
// a two-entry output buffer lets input flow while one result waits on rsp
// reset: synchronous, active high; clears all valid bits and the output buffer count
`include "conductor_fresnel_reflectance_defines.svh"

module conductor_fresnel_reflectance import cfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // cos_incidence[15:0], index_real[31:16], index_imag[47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // reflectance[15:0]
);

   // whole pipeline moves together; it stops only when the output buffer is full
   logic       adv;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign adv        = (cnt_ff != 2'd2);
   assign req_tready = adv;

   // stage 1: capture, cosine saturated to one
   logic           p1_v_ff;
   logic [C_W-1:0] p1_c_in, p1_c_ff, p1_e_ff, p1_k_ff;

   assign p1_c_in = (req_tdata[15:0] > C_W'(ONE_Q15)) ? C_W'(ONE_Q15) : req_tdata[15:0];

   // stage 2: squares of cosine, eta and kappa
   logic              p2_v_ff;
   logic [2*C_W-1:0]  p2_csq;
   logic [C_W-1:0]    p2_c_ff;
   logic [C2_W-1:0]   p2_c2_in, p2_c2_ff;
   logic [SQ_W-1:0]   p2_e2_in, p2_e2_ff, p2_k2_in, p2_k2_ff;

   assign p2_csq   = p1_c_ff * p1_c_ff;
   assign p2_c2_in = p2_csq[C2_W+13:14];
   assign p2_e2_in = p1_e_ff * p1_e_ff;
   assign p2_k2_in = p1_k_ff * p1_k_ff;

   // stage 3: sin^2, t0 = eta^2 - kappa^2 - sin^2, and eta^2 * kappa^2
   logic                   p3_v_ff;
   logic [C_W-1:0]         p3_c_ff;
   logic [C2_W-1:0]        p3_c2_ff, p3_s2_in, p3_s2_ff;
   logic signed [T0_W-1:0] p3_t0_in, p3_t0_ff;
   logic [2*SQ_W-1:0]      p3_ek_in, p3_ek_ff;

   assign p3_s2_in = C2_W'(ONE_Q16) - p2_c2_ff;
   assign p3_t0_in = $signed({2'b00, p2_e2_ff}) - $signed({2'b00, p2_k2_ff})
                   - $signed({{(T0_W-C2_W){1'b0}}, p3_s2_in});
   assign p3_ek_in = p2_e2_ff * p2_k2_ff;

   // stage 4: t0 squared
   logic                     p4_v_ff;
   logic signed [2*T0_W-1:0] p4_sqf;
   logic [SQR_W-1:0]         p4_sq_in, p4_sq_ff;
   logic [2*SQ_W-1:0]        p4_ek_ff;
   side1_type                p4_side_ff;

   assign p4_sqf   = p3_t0_ff * p3_t0_ff;
   assign p4_sq_in = p4_sqf[SQR_W-1:0];

   // first root: ab = isqrt(t0^2 + 4 eta^2 kappa^2), one root bit per stage
   logic [SQ1_N:0] sq1_v_ff;
   sq1_type        sq1_in [SQ1_N+1];
   sq1_type        sq1_ff [SQ1_N+1];

   assign sq1_in[0] = '{rem: '0, root: '0,
                        x: RAD_W'(p4_sq_ff) + {2'b00, p4_ek_ff, 2'b00},
                        side: p4_side_ff};

   for (genvar j = 0; j < SQ1_N; j++) begin : g_sq1
      logic [ABR_W+1:0] pre, trial, diff;
      logic             ge;
      assign pre   = {sq1_ff[j].rem, sq1_ff[j].x[RAD_W-1 -: 2]};
      assign trial = {2'b00, sq1_ff[j].root, 2'b01};
      assign ge    = (pre >= trial);
      assign diff  = pre - trial;
      assign sq1_in[j+1] = '{rem:  ge ? diff[ABR_W-1:0] : pre[ABR_W-1:0],
                             root: {sq1_ff[j].root[AB_W-2:0], ge},
                             x:    sq1_ff[j].x << 2,
                             side: sq1_ff[j].side};
   end

   // between roots: half of ab + t0, t1 = ab + cos^2, and the t3 products
   logic                      x_v_ff;
   logic [AB_W-1:0]           x_ab;
   logic signed [T0_W+1:0]    x_hsum;
   logic [HALF_W-1:0]         x_half_in, x_half_ff;
   logic [C2_W+AB_W-1:0]      x_p1_in, x_p1_ff;
   logic [2*C2_W-1:0]         x_p2_in, x_p2_ff;
   logic [T1_W-1:0]           x_t1_in, x_t1_ff;
   logic [C_W-1:0]            x_c_ff;
   logic [C2_W-1:0]           x_s2_ff;

   assign x_ab      = sq1_ff[SQ1_N].root;
   assign x_hsum    = $signed({2'b00, x_ab})
                    + $signed({{2{sq1_ff[SQ1_N].side.t0[T0_W-1]}}, sq1_ff[SQ1_N].side.t0});
   assign x_half_in = x_hsum[HALF_W:1];
   assign x_p1_in   = sq1_ff[SQ1_N].side.c2 * x_ab;
   assign x_p2_in   = sq1_ff[SQ1_N].side.s2 * sq1_ff[SQ1_N].side.s2;
   assign x_t1_in   = T1_W'(x_ab) + T1_W'(sq1_ff[SQ1_N].side.c2);

   // second root: a = isqrt(half << 16)
   logic [SQ2_N:0] sq2_v_ff;
   sq2_type        sq2_in [SQ2_N+1];
   sq2_type        sq2_ff [SQ2_N+1];

   assign sq2_in[0] = '{rem: '0, root: '0, x: {x_half_ff, 16'b0},
                        side: '{c: x_c_ff, s2: x_s2_ff, t1: x_t1_ff,
                                t3: T3_W'(x_p1_ff[C2_W+AB_W-1:16])
                                  + T3_W'(x_p2_ff[2*C2_W-1:16])}};

   for (genvar j = 0; j < SQ2_N; j++) begin : g_sq2
      logic [AR_W+1:0] pre, trial, diff;
      logic            ge;
      assign pre   = {sq2_ff[j].rem, sq2_ff[j].x[ARG_W-1 -: 2]};
      assign trial = {2'b00, sq2_ff[j].root, 2'b01};
      assign ge    = (pre >= trial);
      assign diff  = pre - trial;
      assign sq2_in[j+1] = '{rem:  ge ? diff[AR_W-1:0] : pre[AR_W-1:0],
                             root: {sq2_ff[j].root[A_W-2:0], ge},
                             x:    sq2_ff[j].x << 2,
                             side: sq2_ff[j].side};
   end

   // stage y: t2 = 2 cos a
   logic               y_v_ff;
   logic [C_W+A_W-1:0] y_prod;
   logic [T2_W-1:0]    y_t2_in, y_t2_ff;
   logic [T1_W-1:0]    y_t1_ff;
   logic [T3_W-1:0]    y_t3_ff;
   logic [C2_W-1:0]    y_s2_ff;

   assign y_prod  = sq2_ff[SQ2_N].side.c * sq2_ff[SQ2_N].root;
   assign y_t2_in = y_prod[T2_W+13:14];

   // stage z: s-term numerator magnitude and sign, denominator, t4
   logic                  z_v_ff;
   logic                  z_ge;
   logic [T1_W-1:0]       z_mag1_in, z_mag1_ff;
   logic                  z_neg1_ff;
   logic [DEN_W-1:0]      z_den1_in, z_den1_ff;
   logic [T2_W+C2_W-1:0]  z_prod;
   logic [T4_W-1:0]       z_t4_in, z_t4_ff;
   logic [T3_W-1:0]       z_t3_ff;

   assign z_ge      = (y_t1_ff >= T1_W'(y_t2_ff));
   assign z_mag1_in = z_ge ? (y_t1_ff - T1_W'(y_t2_ff)) : (T1_W'(y_t2_ff) - y_t1_ff);
   assign z_den1_in = DEN_W'(y_t1_ff) + DEN_W'(y_t2_ff);
   assign z_prod    = y_t2_ff * y_s2_ff;
   assign z_t4_in   = z_prod[T4_W+15:16];

   // first divider: Rs magnitude = (|t1 - t2| << 15) / max(t1 + t2, 1)
   logic             w_neg2;
   logic [DEN_W-1:0] w_sum2;
   logic [DIV_N:0]   dv1_v_ff;
   dv1_type          dv1_in [DIV_N+1];
   dv1_type          dv1_ff [DIV_N+1];

   assign w_neg2 = (z_t3_ff < T3_W'(z_t4_ff));
   assign w_sum2 = DEN_W'(z_t3_ff) + DEN_W'(z_t4_ff);

   assign dv1_in[0] = '{rem: NUM_W'({z_mag1_ff, 15'b0}),
                        den: (z_den1_ff == '0) ? DEN_W'(1) : z_den1_ff,
                        q:   '0,
                        side: '{neg1: z_neg1_ff,
                                neg2: w_neg2,
                                mag2: w_neg2 ? (T3_W'(z_t4_ff) - z_t3_ff)
                                             : (z_t3_ff - T3_W'(z_t4_ff)),
                                den2: (w_sum2 == '0) ? DEN_W'(1) : w_sum2}};

   for (genvar i = 0; i < DIV_N; i++) begin : g_dv1
      localparam int SH = Q_W - 1 - i;
      logic [NUM_W-1:0] dsh;
      logic             ge;
      assign dsh = NUM_W'(dv1_ff[i].den) << SH;
      assign ge  = (dv1_ff[i].rem >= dsh);
      assign dv1_in[i+1] = '{rem:  ge ? (dv1_ff[i].rem - dsh) : dv1_ff[i].rem,
                             den:  dv1_ff[i].den,
                             q:    dv1_ff[i].q | ({Q_W{ge}} & (Q_W'(1) << SH)),
                             side: dv1_ff[i].side};
   end

   // second divider: Rp magnitude = |Rs| |t3 - t4| / max(t3 + t4, 1)
   logic [Q_W-1:0]         v_q1;
   logic signed [RS_W-1:0] v_rs_pos;
   logic [DIV_N:0]         dv2_v_ff;
   dv2_type                dv2_in [DIV_N+1];
   dv2_type                dv2_ff [DIV_N+1];

   assign v_q1     = dv1_ff[DIV_N].q;
   assign v_rs_pos = $signed({1'b0, v_q1});

   assign dv2_in[0] = '{rem: v_q1 * dv1_ff[DIV_N].side.mag2,
                        den: dv1_ff[DIV_N].side.den2,
                        q:   '0,
                        side: '{rs:   dv1_ff[DIV_N].side.neg1 ? -v_rs_pos : v_rs_pos,
                                negp: dv1_ff[DIV_N].side.neg1 ^ dv1_ff[DIV_N].side.neg2}};

   for (genvar i = 0; i < DIV_N; i++) begin : g_dv2
      localparam int SH = Q_W - 1 - i;
      logic [NUM_W-1:0] dsh;
      logic             ge;
      assign dsh = NUM_W'(dv2_ff[i].den) << SH;
      assign ge  = (dv2_ff[i].rem >= dsh);
      assign dv2_in[i+1] = '{rem:  ge ? (dv2_ff[i].rem - dsh) : dv2_ff[i].rem,
                             den:  dv2_ff[i].den,
                             q:    dv2_ff[i].q | ({Q_W{ge}} & (Q_W'(1) << SH)),
                             side: dv2_ff[i].side};
   end

   // mean of the two terms, negative residue to zero, clamp at one
   logic signed [RS_W-1:0]  u_rp_pos, u_rp;
   logic signed [SUM_W-1:0] u_sum;
   logic [OUT_W-1:0]        u_res;

   assign u_rp_pos = $signed({1'b0, dv2_ff[DIV_N].q});
   assign u_rp     = dv2_ff[DIV_N].side.negp ? -u_rp_pos : u_rp_pos;
   assign u_sum    = SUM_W'(dv2_ff[DIV_N].side.rs) + SUM_W'(u_rp);

   always_comb begin
      if (u_sum[SUM_W-1]) begin
         u_res = '0;
      end else if (u_sum[SUM_W-2:1] > (SUM_W-2)'(ONE_Q15)) begin
         u_res = OUT_W'(ONE_Q15);
      end else begin
         u_res = u_sum[OUT_W:1];
      end
   end

   // two-entry output buffer, head in ent0
   logic [OUT_W-1:0] ent0_ff, ent0_in, ent1_ff, ent1_in;

   assign push       = adv && dv2_v_ff[DIV_N];
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = ent0_ff;

   always_comb begin
      cnt_in  = cnt_ff;
      ent0_in = ent0_ff;
      ent1_in = ent1_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push && pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
      if (pop) begin
         if (cnt_ff == 2'd2) begin
            ent0_in = ent1_ff;
         end else begin
            ent0_in = u_res;
         end
      end else if (push) begin
         if (cnt_ff == 2'd0) begin
            ent0_in = u_res;
         end else begin
            ent1_in = u_res;
         end
      end
   end

   // valid bits and buffer count
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff  <= 1'b0;
         p2_v_ff  <= 1'b0;
         p3_v_ff  <= 1'b0;
         p4_v_ff  <= 1'b0;
         sq1_v_ff <= '0;
         x_v_ff   <= 1'b0;
         sq2_v_ff <= '0;
         y_v_ff   <= 1'b0;
         z_v_ff   <= 1'b0;
         dv1_v_ff <= '0;
         dv2_v_ff <= '0;
         cnt_ff   <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (adv) begin
            p1_v_ff  <= req_tvalid;
            p2_v_ff  <= p1_v_ff;
            p3_v_ff  <= p2_v_ff;
            p4_v_ff  <= p3_v_ff;
            sq1_v_ff <= {sq1_v_ff[SQ1_N-1:0], p4_v_ff};
            x_v_ff   <= sq1_v_ff[SQ1_N];
            sq2_v_ff <= {sq2_v_ff[SQ2_N-1:0], x_v_ff};
            y_v_ff   <= sq2_v_ff[SQ2_N];
            z_v_ff   <= y_v_ff;
            dv1_v_ff <= {dv1_v_ff[DIV_N-1:0], z_v_ff};
            dv2_v_ff <= {dv2_v_ff[DIV_N-1:0], dv1_v_ff[DIV_N]};
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      ent0_ff <= ent0_in;
      ent1_ff <= ent1_in;
      if (adv) begin
         p1_c_ff    <= p1_c_in;
         p1_e_ff    <= req_tdata[31:16];
         p1_k_ff    <= req_tdata[47:32];
         p2_c_ff    <= p1_c_ff;
         p2_c2_ff   <= p2_c2_in;
         p2_e2_ff   <= p2_e2_in;
         p2_k2_ff   <= p2_k2_in;
         p3_c_ff    <= p2_c_ff;
         p3_c2_ff   <= p2_c2_ff;
         p3_s2_ff   <= p3_s2_in;
         p3_t0_ff   <= p3_t0_in;
         p3_ek_ff   <= p3_ek_in;
         p4_sq_ff   <= p4_sq_in;
         p4_ek_ff   <= p3_ek_ff;
         p4_side_ff <= '{c: p3_c_ff, c2: p3_c2_ff, s2: p3_s2_ff, t0: p3_t0_ff};
         sq1_ff     <= sq1_in;
         x_half_ff  <= x_half_in;
         x_p1_ff    <= x_p1_in;
         x_p2_ff    <= x_p2_in;
         x_t1_ff    <= x_t1_in;
         x_c_ff     <= sq1_ff[SQ1_N].side.c;
         x_s2_ff    <= sq1_ff[SQ1_N].side.s2;
         sq2_ff     <= sq2_in;
         y_t2_ff    <= y_t2_in;
         y_t1_ff    <= sq2_ff[SQ2_N].side.t1;
         y_t3_ff    <= sq2_ff[SQ2_N].side.t3;
         y_s2_ff    <= sq2_ff[SQ2_N].side.s2;
         z_mag1_ff  <= z_mag1_in;
         z_neg1_ff  <= !z_ge;
         z_den1_ff  <= z_den1_in;
         z_t4_ff    <= z_t4_in;
         z_t3_ff    <= y_t3_ff;
         dv1_ff     <= dv1_in;
         dv2_ff     <= dv2_in;
      end
   end

   // ab never falls below |t0|, so the half term is never negative
   `CFR_ASSERT_IMPLY(clock, reset, a_root_covers_t0, sq1_v_ff[SQ1_N], !x_hsum[T0_W+1], "ab below |t0|")
   // |Rs| never exceeds one
   `CFR_ASSERT_IMPLY(clock, reset, a_rs_bounded, dv1_v_ff[DIV_N], dv1_ff[DIV_N].q <= Q_W'(ONE_Q15), "Rs above one")
   // a shown result is within 0..1
   `CFR_ASSERT_IMPLY(clock, reset, a_out_bounded, rsp_tvalid, rsp_tdata <= OUT_W'(ONE_Q15), "reflectance above one")
   // a push without a pop grows the buffer by one
   `CFR_ASSERT_NEXT(clock, reset, a_buf_grows, push && !pop, cnt_ff == $past(cnt_ff) + 2'd1, "buffer count slip")

endmodule

// ===== dv/cfr_checker.sv =====
module cfr_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   output int          fail_count,
   output int          pending_count,
   output int          result_count
);

   logic [15:0] reflectance_queue[$];

   // floor square root, bit by bit from the top
   function automatic logic [35:0] floor_sqrt(input logic [71:0] x);
      logic [35:0] r;
      logic [35:0] cand;
      r = '0;
      for (int b = 35; b >= 0; b--) begin
         cand = r | (36'd1 << b);
         if ({36'd0, cand} * {36'd0, cand} <= x) r = cand;
      end
      return r;
   endfunction

   function automatic logic [15:0] predict_reflectance(input logic [47:0] item);
      longint c, e, k, c2, s2, e2, k2, t0, t0mag, ab, a, half;
      longint t1, t2, t3, t4, num, den, rs, rp, total;
      logic [71:0] rad;
      c = item[15:0];
      e = item[31:16];
      k = item[47:32];
      // cosine above one saturates
      if (c > 32768) c = 32768;
      c2 = (c * c) >>> 14;
      s2 = 65536 - c2;
      e2 = e * e;
      k2 = k * k;
      t0 = e2 - k2 - s2;
      t0mag = (t0 < 0) ? -t0 : t0;
      rad = 72'(t0mag) * 72'(t0mag) + ((72'(e2) * 72'(k2)) << 2);
      ab = longint'(floor_sqrt(rad));
      half = ab + t0;
      if (half < 0) half = 0;
      half = half / 2;
      a = longint'(floor_sqrt(72'(half) << 16));
      t1 = ab + c2;
      t2 = (c * a) >>> 14;
      num = t1 - t2;
      den = t1 + t2;
      if (den < 1) den = 1;
      rs = (num * 32768) / den;
      t3 = ((c2 * ab) >>> 16) + ((s2 * s2) >>> 16);
      t4 = (t2 * s2) >>> 16;
      den = t3 + t4;
      if (den < 1) den = 1;
      rp = (rs * (t3 - t4)) / den;
      total = rs + rp;
      // negative rounding residue becomes zero
      if (total < 0) total = 0;
      total = total / 2;
      if (total > 32768) total = 32768;
      return 16'(total);
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      fail_count++;
   endtask

   assign pending_count = reflectance_queue.size();

   always @(posedge clock) begin
      if (reset) begin
         fail_count = 0;
         result_count = 0;
      end else begin
         if (req_tvalid && req_tready)
            reflectance_queue.push_back(predict_reflectance(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (reflectance_queue.size() == 0)
               report_mismatch("unexpected transfer", rsp_tdata, 16'd0);
            else begin
               logic [15:0] want;
               want = reflectance_queue.pop_front();
               if (rsp_tdata !== want) report_mismatch("reflectance", rsp_tdata, want);
            end
         end
      end
   end

endmodule

// ===== dv/tb_conductor_fresnel_reflectance.sv =====
module tb_conductor_fresnel_reflectance;
   import cfr_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;    // cos_incidence[15:0], index_real[31:16], index_imag[47:32]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;    // reflectance[15:0]
   int          fail_count;
   int          pending_count;
   int          result_count;
   int          sent_count;
   bit          hold_off;     // long receiver stall requested by the sender side
   bit          stimulus_done;

   conductor_fresnel_reflectance dut (.*);

   cfr_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // random cosine biased toward the interesting corners
   function automatic logic [15:0] pick_cos();
      case ($urandom_range(0, 5))
         0: return 16'd32768;
         1: return 16'($urandom_range(0, 64));
         2: return 16'($urandom_range(32769, 65535));   // above one, saturates
         default: return 16'($urandom_range(0, 32768));
      endcase
   endfunction

   // index: mostly physical metals/dielectrics, sometimes full range
   function automatic logic [15:0] pick_index();
      case ($urandom_range(0, 4))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 16));
         default: return 16'($urandom_range(0, 2560));
      endcase
   endfunction

   // one transfer, with a random gap before it unless no_gap is set
   task automatic send_item(input logic [15:0] c, input logic [15:0] e, input logic [15:0] k,
                            input bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {k, e, c};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int stall;
      bit held;
      held = 0;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off && !held) begin
            rsp_tready <= 1'b0;
            repeat (300) @(negedge clock);
            held = 1;
         end
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin
      logic [15:0] corner_vals[4];
      int burst;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      reset      = 1'b1;
      sent_count = 0;
      hold_off   = 0;
      stimulus_done = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, normal incidence, grazing, saturated cosine,
      // zero index (zero denominators), huge index
      corner_vals = '{16'd0, 16'd1, 16'd256, 16'hFFFF};
      foreach (corner_vals[i]) foreach (corner_vals[j]) begin
         send_item((i % 2) ? 16'd32768 : 16'd0, corner_vals[i], corner_vals[j], 0);
      end
      send_item(16'hFFFF, 16'd384, 16'd0, 0);
      send_item(16'd32769, 16'd40, 16'd900, 0);
      send_item(16'd23170, 16'hFFFF, 16'hFFFF, 0);
      send_item(16'd1, 16'd1, 16'hFFFF, 0);
      send_item(16'hAAAA, 16'h5555, 16'hAAAA, 0);
      send_item(16'h5555, 16'hAAAA, 16'h5555, 0);

      // pause until every expected result has come
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);

      // long receiver hold-off while the sender keeps offering back to back
      hold_off = 1;
      repeat (200) send_item(pick_cos(), pick_index(), pick_index(), 1);

      while (sent_count < 1470) begin
         burst = ($urandom_range(0, 3) == 0) ? 30 : 1;
         repeat (burst) send_item(pick_cos(), pick_index(), pick_index(), burst > 1);
      end
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (110) @(negedge clock);

      $display("covered %0d transfers, %0d results: corners, saturated cosine,", sent_count,
               result_count);
      $display("zero and full-scale indices, long output backpressure");
      if (fail_count == 0)
         $display("tb_conductor_fresnel_reflectance: PASS");
      else
         $display("tb_conductor_fresnel_reflectance: FAIL");
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("tb_conductor_fresnel_reflectance: FAIL");
      $finish;
   end

endmodule
